>>> hdl/hhls_pkg.sv
// Shared types, constants and helper functions of the HTTP header length scanner.
`timescale 1ns / 1ps

package hhls_pkg;

    // Field widths
    localparam int COUNT_BITS     = 17;
    localparam int LENGTH_BITS    = 28;
    localparam int REQ_BITS       = LENGTH_BITS + 1;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_DATA_BITS  = 28;
    localparam int CFG_INDEX_BITS = 1;
    localparam int NAME_POS_BITS  = 4;

    // Header name "content-length" has this many characters
    localparam logic [NAME_POS_BITS-1:0] NAME_CHARS = 4'd14;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_HEADER = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_BODY   = 1'b1;

    // Configuration reset values
    localparam logic [COUNT_BITS-1:0]  MAX_HEADER_RESET = 17'd65536;
    localparam logic [LENGTH_BITS-1:0] MAX_BODY_RESET   = 28'd8388608;

    // Saturated length value
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    // Smallest header: a lone CR LF CR LF
    localparam logic [COUNT_BITS-1:0] MIN_HEADER = 17'd4;

    // Characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    // Where the parser is within the current header line
    typedef enum logic [2:0] {
        PH_NAME,
        PH_BLANK,
        PH_LEAD,
        PH_DIGITS,
        PH_IGNORE,
        PH_STOPPED
    } t_phase;

    // Progress through CR LF CR LF
    typedef enum logic [1:0] {
        TP_NONE,
        TP_CR,
        TP_CRLF,
        TP_CRLFCR
    } t_term;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK,
        ST_HDR_LONG,
        ST_BODY_LARGE
    } t_status;

    typedef struct packed {
        t_status                status;
        logic [COUNT_BITS-1:0]  header_length;
        logic [LENGTH_BITS-1:0] body_length;
        logic [REQ_BITS-1:0]    request_length;
    } t_result;

    // Lower-case header name, one character per position
    function automatic logic [7:0] name_char(input logic [NAME_POS_BITS-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | 8'h20) : c;
        return lc;
    endfunction

    // Space, tab, LF, VT, FF or CR
    function automatic logic is_ws(input logic [7:0] c);
        logic ws;
        ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        return ws;
    endfunction

endpackage

>>> hdl/hhls_ifs.sv
// Valid/ready channel interfaces for request bytes and scan results.
`timescale 1ns / 1ps

interface hhls_req_if
    import hhls_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_request;

    modport source (output valid, output data_byte, output start_of_request, input ready);
    modport sink   (input valid, input data_byte, input start_of_request, output ready);
endinterface

interface hhls_res_if
    import hhls_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  header_length;
    logic [LENGTH_BITS-1:0] body_length;
    logic [REQ_BITS-1:0]    request_length;

    modport source (output valid, output status, output header_length,
                    output body_length, output request_length, input ready);
    modport sink   (input valid, input status, input header_length,
                    input body_length, input request_length, output ready);
endinterface

>>> hdl/hhls_parser.sv
// Per-byte header parser: parser state registers and the next-state logic.
`timescale 1ns / 1ps

module hhls_parser
    import hhls_pkg::*;
#(
    parameter int VALUE_WINDOW = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_sor,
    input  logic [COUNT_BITS-1:0]  i_max_header,
    input  logic [LENGTH_BITS-1:0] i_max_body,
    output logic                   o_res_valid,
    output t_result                o_res
);

    localparam int VC_BITS   = $clog2(VALUE_WINDOW + 1);
    localparam int PROD_BITS = LENGTH_BITS + 4;

    logic [COUNT_BITS-1:0]    r_bytes, n_bytes, c_bytes;
    t_term                    r_term, n_term, c_term;
    logic [NAME_POS_BITS-1:0] r_pos, n_pos, c_pos;
    logic                     r_match, n_match, c_match;
    t_phase                   r_phase, n_phase, c_phase;
    logic [VC_BITS-1:0]       r_vcount, n_vcount, c_vcount;
    logic [LENGTH_BITS-1:0]   r_acc, n_acc, c_acc;
    logic                     r_ovf, n_ovf, c_ovf;
    logic                     r_neg, n_neg, c_neg;
    logic                     r_capt, n_capt, c_capt;
    logic                     r_fin, n_fin, c_fin;

    // Value character step results
    t_phase                   vc_in_phase, vc_phase;
    logic [VC_BITS-1:0]       vc_count;
    logic [LENGTH_BITS-1:0]   vc_acc;
    logic                     vc_ovf, vc_neg;
    logic [PROD_BITS-1:0]     prod;
    logic [PROD_BITS-1:0]     acc_ext;

    logic                     last_cr;
    logic                     oversize_raw;
    logic [LENGTH_BITS-1:0]   cl;
    logic                     res_valid;
    t_result                  res_word;

    // A start-of-request byte sees freshly cleared state
    always_comb begin
        if (i_sor) begin
            c_bytes  = '0;
            c_term   = TP_NONE;
            c_pos    = '0;
            c_match  = 1'b1;
            c_phase  = PH_NAME;
            c_vcount = '0;
            c_acc    = '0;
            c_ovf    = 1'b0;
            c_neg    = 1'b0;
            c_capt   = 1'b0;
            c_fin    = 1'b0;
        end else begin
            c_bytes  = r_bytes;
            c_term   = r_term;
            c_pos    = r_pos;
            c_match  = r_match;
            c_phase  = r_phase;
            c_vcount = r_vcount;
            c_acc    = r_acc;
            c_ovf    = r_ovf;
            c_neg    = r_neg;
            c_capt   = r_capt;
            c_fin    = r_fin;
        end
    end

    // Multiply the accumulator by ten and add the digit
    assign acc_ext = PROD_BITS'(c_acc);
    assign prod    = (acc_ext << 3) + (acc_ext << 1) + PROD_BITS'(i_data_byte[3:0]);

    // One character of the value, strtoul style
    always_comb begin
        vc_in_phase = (c_phase == PH_BLANK) ? PH_LEAD : c_phase;
        vc_phase    = vc_in_phase;
        vc_count    = c_vcount;
        vc_acc      = c_acc;
        vc_ovf      = c_ovf;
        vc_neg      = c_neg;
        if (c_vcount >= VC_BITS'(VALUE_WINDOW)) begin
            vc_phase = PH_IGNORE;
        end else begin
            vc_count = c_vcount + 1'b1;
            priority if (vc_in_phase == PH_LEAD && is_ws(i_data_byte)) begin
                vc_phase = PH_LEAD;
            end else if (vc_in_phase == PH_LEAD &&
                         (i_data_byte == CH_PLUS || i_data_byte == CH_MINUS)) begin
                vc_phase = PH_DIGITS;
                vc_neg   = (i_data_byte == CH_MINUS);
            end else if (i_data_byte >= CH_ZERO && i_data_byte <= CH_NINE) begin
                vc_phase = PH_DIGITS;
                if (!c_ovf) begin
                    if (prod > PROD_BITS'(LEN_MAX)) begin
                        vc_ovf = 1'b1;
                        vc_acc = LEN_MAX;
                    end else begin
                        vc_acc = prod[LENGTH_BITS-1:0];
                    end
                end
            end else begin
                vc_phase = PH_IGNORE;
            end
        end
    end

    // Content length and overflow verdict at the terminator
    assign oversize_raw = c_ovf || (c_neg && c_acc != '0);
    assign cl           = oversize_raw ? LEN_MAX : (c_neg ? '0 : c_acc);
    assign last_cr      = (c_term == TP_CR) || (c_term == TP_CRLFCR);

    // Next state and result for one byte
    always_comb begin
        n_bytes   = c_bytes;
        n_term    = c_term;
        n_pos     = c_pos;
        n_match   = c_match;
        n_phase   = c_phase;
        n_vcount  = c_vcount;
        n_acc     = c_acc;
        n_ovf     = c_ovf;
        n_neg     = c_neg;
        n_capt    = c_capt;
        n_fin     = c_fin;
        res_valid = 1'b0;
        res_word  = '0;

        if (!c_fin) begin
            if (c_bytes == '1 ||
                ({1'b0, c_bytes} + 1'b1) > {1'b0, i_max_header}) begin
                // Header too long: report and stop
                n_fin              = 1'b1;
                res_valid          = 1'b1;
                res_word.status    = ST_HDR_LONG;
            end else begin
                n_bytes = c_bytes + 1'b1;

                // Line end or one byte of the line
                if (i_data_byte == CH_LF && last_cr && c_phase != PH_STOPPED) begin
                    n_pos    = '0;
                    n_match  = 1'b1;
                    n_vcount = '0;
                    n_phase  = (c_phase == PH_NAME && c_pos == 4'd1) ? PH_STOPPED : PH_NAME;
                end else begin
                    unique case (c_phase)
                        PH_NAME: begin
                            if (i_data_byte == CH_COLON) begin
                                if (c_match && c_pos == NAME_CHARS && !c_capt) begin
                                    n_capt  = 1'b1;
                                    n_phase = PH_BLANK;
                                end else begin
                                    n_phase = PH_IGNORE;
                                end
                            end else begin
                                if (c_pos >= NAME_CHARS ||
                                    to_lower(i_data_byte) != name_char(c_pos)) begin
                                    n_match = 1'b0;
                                end
                                if (c_pos != '1) begin
                                    n_pos = c_pos + 1'b1;
                                end
                            end
                        end
                        PH_BLANK, PH_LEAD, PH_DIGITS: begin
                            if (!(c_phase == PH_BLANK &&
                                  (i_data_byte == CH_SPACE || i_data_byte == CH_TAB))) begin
                                n_phase  = vc_phase;
                                n_vcount = vc_count;
                                n_acc    = vc_acc;
                                n_ovf    = vc_ovf;
                                n_neg    = vc_neg;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // Track the terminator
                priority if (i_data_byte == CH_CR) begin
                    n_term = (c_term == TP_CRLF) ? TP_CRLFCR : TP_CR;
                end else if (i_data_byte == CH_LF && c_term == TP_CR) begin
                    n_term = TP_CRLF;
                end else if (i_data_byte == CH_LF && c_term == TP_CRLFCR) begin
                    n_fin                  = 1'b1;
                    res_valid              = 1'b1;
                    res_word.header_length = n_bytes;
                    res_word.body_length   = cl;
                    if (oversize_raw || cl > i_max_body) begin
                        res_word.status = ST_BODY_LARGE;
                    end else begin
                        res_word.status         = ST_OK;
                        res_word.request_length = REQ_BITS'(n_bytes) + REQ_BITS'(cl);
                    end
                end else begin
                    n_term = TP_NONE;
                end
            end
        end
    end

    assign o_res_valid = i_fire && res_valid;
    assign o_res       = res_word;

    // Advance parser state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes  <= '0;
            r_term   <= TP_NONE;
            r_pos    <= '0;
            r_match  <= 1'b1;
            r_phase  <= PH_NAME;
            r_vcount <= '0;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
            r_neg    <= 1'b0;
            r_capt   <= 1'b0;
            r_fin    <= 1'b0;
        end else if (i_fire) begin
            r_bytes  <= n_bytes;
            r_term   <= n_term;
            r_pos    <= n_pos;
            r_match  <= n_match;
            r_phase  <= n_phase;
            r_vcount <= n_vcount;
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
            r_neg    <= n_neg;
            r_capt   <= n_capt;
            r_fin    <= n_fin;
        end
    end

endmodule

>>> hdl/hhls_out_reg.sv
// Result output register driving the result channel.
`timescale 1ns / 1ps

module hhls_out_reg
    import hhls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_res,
    output logic        o_can_load,
    hhls_res_if.source  o_res
);

    logic    r_valid;
    t_result r_res;

    // Room when empty or when the held word leaves this cycle
    assign o_can_load = !r_valid || o_res.ready;

    // Hold the word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.status         = r_res.status;
    assign o_res.header_length  = r_res.header_length;
    assign o_res.body_length    = r_res.body_length;
    assign o_res.request_length = r_res.request_length;

endmodule

>>> hdl/http_header_length_scanner_top.sv
// Top level of the HTTP header length scanner: input register, config and parser.
`timescale 1ns / 1ps

// Takes one request byte per cycle while not stalled and emits one result word per
// request once the CR LF CR LF terminator is seen (or the header limit is hit). A
// byte goes through an input register, then combinational parse logic (character
// compares and one multiply-by-ten on the length accumulator) that updates the
// parser state registers and loads the output register, which holds the result
// word until the result side takes it.
// Throughput is one byte per cycle as long as the result side takes its words;
// the input register only holds while the output register is full and stalled.
// Bytes after a result are dropped until a byte flagged start_of_request. The user
// must write limits via the config port while no byte is in flight; unenforced.

module http_header_length_scanner_top
    import hhls_pkg::*;
#(
    parameter int VALUE_WINDOW = 31
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    hhls_req_if.sink                  i_req,
    hhls_res_if.source                o_res,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_sor;
    logic [COUNT_BITS-1:0]  r_max_header;
    logic [LENGTH_BITS-1:0] r_max_body;

    logic                   can_load;
    logic                   fire;
    logic                   res_valid;
    t_result                res_word;

    // Process the held byte when the output register has room
    assign fire        = r_in_valid && can_load;
    assign i_req.ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_byte <= i_req.data_byte;
            r_in_sor  <= i_req.start_of_request;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_header <= MAX_HEADER_RESET;
            r_max_body   <= MAX_BODY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_HEADER: r_max_header <= i_cfg_data[COUNT_BITS-1:0];
                CFG_MAX_BODY:   r_max_body   <= i_cfg_data[LENGTH_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    hhls_parser #(
        .VALUE_WINDOW (VALUE_WINDOW)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_data_byte  (r_in_byte),
        .i_sor        (r_in_sor),
        .i_max_header (r_max_header),
        .i_max_body   (r_max_body),
        .o_res_valid  (res_valid),
        .o_res        (res_word)
    );

    hhls_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res_word),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

endmodule

>>> hdl/hhls_checker.sv
// Port-level checks on the scanner's result channel, bound to the top level.
`timescale 1ns / 1ps

module hhls_checker
    import hhls_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [STATUS_BITS-1:0] i_status,
    input logic [COUNT_BITS-1:0]  i_header_length,
    input logic [LENGTH_BITS-1:0] i_body_length,
    input logic [REQ_BITS-1:0]    i_request_length
);

    // Stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) &&
            $stable(i_header_length) && $stable(i_body_length) &&
            $stable(i_request_length))
        else $error("result word changed while stalled");

    // Good request: request length is the sum
    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_OK |->
            i_request_length == REQ_BITS'(i_header_length) + REQ_BITS'(i_body_length))
        else $error("request length is not header plus content");

    // Header overrun reports zeros
    a_hdr_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_HDR_LONG |->
            i_header_length == '0 && i_body_length == '0 && i_request_length == '0)
        else $error("header overrun with nonzero lengths");

    // Body too large carries no request length
    a_body_large: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_BODY_LARGE |-> i_request_length == '0)
        else $error("oversize body with nonzero request length");

    // A terminator takes at least four bytes
    a_min_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_OK || i_status == ST_BODY_LARGE) |->
            i_header_length >= MIN_HEADER)
        else $error("header shorter than a terminator");

endmodule

bind http_header_length_scanner_top hhls_checker u_hhls_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_status         (o_res.status),
    .i_header_length  (o_res.header_length),
    .i_body_length    (o_res.body_length),
    .i_request_length (o_res.request_length)
);
